[sv/cfp_pkg.sv]
// Shared types and constants of the command frame parser.
// Used by cfp_match and command_frame_parser; depends on nothing else.
`default_nettype none

package cfp_pkg;

    // Largest number of payload bytes that are passed out per frame.
    localparam int MAX_DATA = 256;
    // Width of the received byte count; it must be able to hold MAX_DATA itself.
    localparam int CNT_W    = $clog2(MAX_DATA + 1);

    localparam int CODE_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int EV_W     = 2;
    localparam int REG_IDX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_START_CODE       = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PARAM_ACK_CODE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_INPUT_PDU_CODE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PARAM_ACK_LENGTH = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_INPUT_PDU_LENGTH = 3'd4;

    // Event codes of a completed frame.
    localparam logic [EV_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_W-1:0] EV_START = 2'd1;
    localparam logic [EV_W-1:0] EV_PARAM = 2'd2;
    localparam logic [EV_W-1:0] EV_INPUT = 2'd3;

    // Parser phases.
    localparam logic [2:0] PH_CMD_LO = 3'd0;
    localparam logic [2:0] PH_CMD_HI = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;

    typedef struct packed {
        logic [CODE_W-1:0] start_code;
        logic [CODE_W-1:0] param_ack_code;
        logic [CODE_W-1:0] input_pdu_code;
        logic [CODE_W-1:0] param_ack_length;
        logic [CODE_W-1:0] input_pdu_length;
    } t_cfg;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic              frame_done;
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic              param_wait_clear;
    } t_result;

endpackage

`default_nettype wire

[sv/cfp_match.sv]
// Command matcher: decides the event raised by a completed frame.
// Depends on cfp_pkg for the configuration struct and the event codes.
`default_nettype none

module cfp_match
    import cfp_pkg::*;
(
    input  wire t_cfg              i_cfg,
    input  wire                    i_done,
    input  wire [CODE_W-1:0]       i_command,
    input  wire [CODE_W-1:0]       i_length,
    input  wire                    i_param_wait,
    input  wire                    i_input_wait,
    output logic [EV_W-1:0]        o_event_res,
    output logic                   o_param_wait_clear
);

    // Priority chain: the first code that matches decides, even if its checks fail.
    always_comb begin
        o_event_res        = EV_NONE;
        o_param_wait_clear = 1'b0;
        if (i_done) begin
            if (i_command == i_cfg.start_code) begin
                if (i_length == '0) begin
                    o_event_res = EV_START;
                end
            end else if (i_command == i_cfg.param_ack_code) begin
                if (i_length == i_cfg.param_ack_length && i_param_wait) begin
                    o_event_res        = EV_PARAM;
                    o_param_wait_clear = 1'b1;
                end
            end else if (i_command == i_cfg.input_pdu_code) begin
                if (i_length == i_cfg.input_pdu_length && i_input_wait) begin
                    o_event_res = EV_INPUT;
                end
            end
        end
    end

endmodule

`default_nettype wire

[sv/command_frame_parser.sv]
// Command frame parser: each accepted byte's result is registered. Throughput
// one byte per cycle unless the input stalls; a two-entry output stage keeps
// taking bytes while one result waits at the output. The parser state is
// updated in the same cycle as the byte is accepted, so bytes follow with no gap.
// Reset (synchronous, active low) clears the frame context, the registers and
// the valid flags of both output entries; there is no clearing pass.
`default_nettype none

module command_frame_parser
    import cfp_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,

    // Configuration write port.
    input  wire                    i_cfg_we,
    input  wire [REG_IDX_W-1:0]    i_cfg_index,
    input  wire [CODE_W-1:0]       i_cfg_wdata,

    // Input channel.
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire                    i_mode,
    input  wire [BYTE_W-1:0]       i_rx_byte,
    input  wire                    i_param_wait,
    input  wire                    i_input_wait,

    // Output channel.
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic [EV_W-1:0]        o_event_res,
    output logic                   o_frame_done,
    output logic                   o_payload_valid,
    output logic [BYTE_W-1:0]      o_payload_byte,
    output logic [BYTE_W-1:0]      o_payload_index,
    output logic                   o_param_wait_clear
);

    // ------------------------------------------------------------------
    // Configuration registers. The user is to write them only while the parser
    // is idle; the block does not enforce this, so they need no shadow copy.
    // ------------------------------------------------------------------
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_CODE:       r_cfg.start_code       <= i_cfg_wdata;
                REG_PARAM_ACK_CODE:   r_cfg.param_ack_code   <= i_cfg_wdata;
                REG_INPUT_PDU_CODE:   r_cfg.input_pdu_code   <= i_cfg_wdata;
                REG_PARAM_ACK_LENGTH: r_cfg.param_ack_length <= i_cfg_wdata;
                REG_INPUT_PDU_LENGTH: r_cfg.input_pdu_length <= i_cfg_wdata;
                default: begin
                    // Writes to indexes beyond the register list are ignored.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Frame context.
    // ------------------------------------------------------------------
    logic [2:0]        r_phase;
    logic [CODE_W-1:0] r_command;
    logic [CODE_W-1:0] r_length;
    logic [CNT_W-1:0]  r_count;

    logic [2:0]        n_phase;
    logic [CODE_W-1:0] n_command;
    logic [CODE_W-1:0] n_length;
    logic [CNT_W-1:0]  n_count;

    logic              w_accept;
    logic              w_done;
    logic [CODE_W-1:0] w_match_length;
    t_result           w_result;
    logic [EV_W-1:0]   w_event_res;
    logic              w_param_wait_clear;

    // The skid entry being full is the only reason to hold the input back.
    logic r_skid_valid;
    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid && !r_skid_valid;

    // Next-state logic for one received byte. A timeout transfer clears the
    // context and yields an all-zero result.
    always_comb begin
        n_phase        = r_phase;
        n_command      = r_command;
        n_length       = r_length;
        n_count        = r_count;
        w_done         = 1'b0;
        w_match_length = r_length;
        w_result       = '0;

        if (!i_mode) begin
            case (r_phase)
                PH_CMD_LO: begin
                    n_command = {{(CODE_W-BYTE_W){1'b0}}, i_rx_byte};
                    n_phase   = PH_CMD_HI;
                end
                PH_CMD_HI: begin
                    n_command = {i_rx_byte, r_command[BYTE_W-1:0]};
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_length = {{(CODE_W-BYTE_W){1'b0}}, i_rx_byte};
                    n_phase  = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_length       = {i_rx_byte, r_length[BYTE_W-1:0]};
                    w_match_length = n_length;
                    // A frame with no payload completes on its last length byte.
                    if (n_length == '0) begin
                        w_done = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                        n_count = '0;
                    end
                end
                PH_DATA: begin
                    // Bytes beyond the limit are dropped and the count stays put.
                    if (r_count < CNT_W'(MAX_DATA)) begin
                        w_result.payload_valid = 1'b1;
                        w_result.payload_byte  = i_rx_byte;
                        w_result.payload_index = r_count[BYTE_W-1:0];
                        n_count                = r_count + 1'b1;
                    end
                    if (r_length <= CODE_W'(n_count)) begin
                        w_done = 1'b1;
                    end
                end
                default: begin
                    // Unreachable phases ignore the byte.
                end
            endcase
        end

        w_result.frame_done       = w_done;
        w_result.event_res        = w_event_res;
        w_result.param_wait_clear = w_param_wait_clear;

        // Completion and timeout both end the frame.
        if (i_mode || w_done) begin
            n_phase   = PH_CMD_LO;
            n_command = '0;
            n_length  = '0;
            n_count   = '0;
        end
    end

    // The command register is complete by the time a frame can finish, so
    // the matcher reads it directly.
    cfp_match u_match (
        .i_cfg              (r_cfg),
        .i_done             (w_done),
        .i_command          (r_command),
        .i_length           (w_match_length),
        .i_param_wait       (i_param_wait),
        .i_input_wait       (i_input_wait),
        .o_event_res        (w_event_res),
        .o_param_wait_clear (w_param_wait_clear)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CMD_LO;
            r_command <= '0;
            r_length  <= '0;
            r_count   <= '0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_command <= n_command;
            r_length  <= n_length;
            r_count   <= n_count;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: a result register plus one skid entry. A new result goes
    // straight to the output when it is free; otherwise it waits in the skid
    // entry, which then holds the input back until the output moves on.
    // ------------------------------------------------------------------
    logic    r_out_valid;
    t_result r_out;
    t_result r_skid;
    logic    w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= w_accept;
            end
        end else if (w_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_accept) begin
                r_out <= w_result;
            end
        end else if (w_accept) begin
            r_skid <= w_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_res        = r_out.event_res;
    assign o_frame_done       = r_out.frame_done;
    assign o_payload_valid    = r_out.payload_valid;
    assign o_payload_byte     = r_out.payload_byte;
    assign o_payload_index    = r_out.payload_index;
    assign o_param_wait_clear = r_out.param_wait_clear;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The skid entry only fills behind a held output result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while output register is empty");

    // An event is only raised by a completed frame.
    a_event_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_res != EV_NONE) |-> o_frame_done)
        else $error("event raised without frame completion");

    // The wait-flag clear goes only with a parameter confirmation.
    a_clear_with_param: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_param_wait_clear) |-> (o_event_res == EV_PARAM))
        else $error("parameter wait clear without parameter event");

    // The parser never leaves the five defined phases.
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_DATA)
        else $error("parser phase out of range");

    // The received count saturates at the payload limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_DATA))
        else $error("received count beyond payload limit");

endmodule

`default_nettype wire
